// ===== src/byte_packet_framer_deframer_macros.svh =====
// Assertion macros used by the framer/deframer core module.
// Each use names the label and the property terms; clock and reset are clk and arst_n.
`ifndef BYTE_PACKET_FRAMER_DEFRAMER_MACROS_SVH
`define BYTE_PACKET_FRAMER_DEFRAMER_MACROS_SVH
`ifndef ASSERT_OFF
`define BPFD_ASSERT(label, expr) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (expr)) \
		else $error("bpfd: invariant violated");
`define BPFD_ASSERT_NEXT(label, pre, post) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error("bpfd: next-cycle check violated");
`else
`define BPFD_ASSERT(label, expr)
`define BPFD_ASSERT_NEXT(label, pre, post)
`endif
`endif

// ===== src/bpfd_pkg.sv =====
package bpfd_pkg;

	localparam int BUF_BYTES = 64;
	localparam int AW        = $clog2(BUF_BYTES);
	localparam int PW        = $clog2(BUF_BYTES + 1);
	localparam int PLW       = 6;
	localparam int HDR_BYTES = 2;
	localparam int MIN_LEN   = 3;

	localparam logic [7:0] START_RESET = 8'h55;

	// raw operation codes on the input port
	localparam logic [2:0] OPC_RECV  = 3'd0;
	localparam logic [2:0] OPC_READ  = 3'd1;
	localparam logic [2:0] OPC_LOAD  = 3'd2;
	localparam logic [2:0] OPC_PULL  = 3'd3;
	localparam logic [2:0] OPC_CLEAR = 3'd4;

	// queue sizing between the parts
	localparam int QD  = 2;
	localparam int QAW = $clog2(QD);
	localparam int QCW = $clog2(QD + 1);

	typedef enum logic [2:0] {
		K_RECV,
		K_READ,
		K_LOAD,
		K_PULL,
		K_CLEAR,
		K_NOP
	} kind_t;

	typedef struct packed {
		kind_t      kind;
		logic [7:0] data;
		logic       last;
	} cmd_t;

	typedef struct packed {
		logic [7:0]     data;
		logic           acc;
		logic           last;
		logic [PLW-1:0] plen;
	} res_t;

endpackage

// ===== src/bpfd_front.sv =====
module bpfd_front
	import bpfd_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	output logic       full,
	input  logic [2:0] operation,
	input  logic [7:0] data_in,
	input  logic       load_last,
	output logic       cmd_valid,
	output cmd_t       cmd,
	input  logic       cmd_pop
);

	cmd_t             slot_q [QD];
	logic [QAW-1:0]   wr_q;
	logic [QAW-1:0]   rd_q;
	logic [QCW-1:0]   cnt_q;
	cmd_t             dec;
	logic             wr_en;
	logic             rd_en;

	// classify the raw code; unused codes become a no-op
	always_comb begin
		dec.data = data_in;
		dec.last = load_last;
		case (operation)
			OPC_RECV:  dec.kind = K_RECV;
			OPC_READ:  dec.kind = K_READ;
			OPC_LOAD:  dec.kind = K_LOAD;
			OPC_PULL:  dec.kind = K_PULL;
			OPC_CLEAR: dec.kind = K_CLEAR;
			default:   dec.kind = K_NOP;
		endcase
	end

	assign full      = (cnt_q == QCW'(QD));
	assign cmd_valid = (cnt_q != '0);
	assign cmd       = slot_q[rd_q];
	assign wr_en     = push && !full;
	assign rd_en     = cmd_pop && cmd_valid;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			slot_q[wr_q] <= dec;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (wr_en) begin
				wr_q <= (wr_q == QAW'(QD - 1)) ? '0 : wr_q + 1'b1;
			end
			if (rd_en) begin
				rd_q <= (rd_q == QAW'(QD - 1)) ? '0 : rd_q + 1'b1;
			end
			if (wr_en && !rd_en) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (rd_en && !wr_en) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

// ===== src/bpfd_outq.sv =====
module bpfd_outq
	import bpfd_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic res_push,
	input  res_t res_in,
	output logic res_full,
	output logic empty,
	input  logic pop,
	output res_t res_out
);

	res_t           slot_q [QD];
	logic [QAW-1:0] wr_q;
	logic [QAW-1:0] rd_q;
	logic [QCW-1:0] cnt_q;
	logic           wr_en;
	logic           rd_en;

	assign res_full = (cnt_q == QCW'(QD));
	assign empty    = (cnt_q == '0);
	assign res_out  = slot_q[rd_q];
	assign wr_en    = res_push && !res_full;
	assign rd_en    = pop && !empty;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			slot_q[wr_q] <= res_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (wr_en) begin
				wr_q <= (wr_q == QAW'(QD - 1)) ? '0 : wr_q + 1'b1;
			end
			if (rd_en) begin
				rd_q <= (rd_q == QAW'(QD - 1)) ? '0 : rd_q + 1'b1;
			end
			if (wr_en && !rd_en) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (rd_en && !wr_en) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

// ===== src/bpfd_core.sv =====
`include "byte_packet_framer_deframer_macros.svh"
module bpfd_core
	import bpfd_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic [7:0] cfg_data,
	input  logic       cmd_valid,
	input  cmd_t       cmd,
	output logic       cmd_pop,
	input  logic       out_full,
	output logic       res_push,
	output res_t       res
);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_SUM  = 2'd1;
	localparam logic [1:0] S_READ = 2'd2;

	logic [1:0]    state_q, state_d;
	logic [7:0]    start_q;
	logic [PW-1:0] len_q, len_d;
	logic [PW-1:0] wp_q, wp_d;
	logic [PW-1:0] rp_q, rp_d;
	logic          valid_q, valid_d;
	logic [7:0]    sum_q, sum_d;
	logic          loading_q, loading_d;
	logic [7:0]    hdr0_q, hdr0_d;
	logic [7:0]    hdr1_q, hdr1_d;
	logic [AW-1:0] idx_q, idx_d;

	logic [7:0]    store_q [BUF_BYTES];
	logic          mem_we;
	logic [AW-1:0] mem_wa;
	logic [7:0]    mem_wd;
	logic          mem_re;
	logic [AW-1:0] mem_ra;

	logic          res_v_s1;
	res_t          res_s1;
	logic          sel_mem_s1;
	logic [7:0]    rdata_s1;

	logic          out_ready;
	logic          adv;
	logic          take;
	logic          iss;
	logic          iss_mem;
	res_t          iss_res;
	logic [PW-1:0] eff_wp;
	logic [7:0]    eff_sum;
	logic          ready;

	assign out_ready = !out_full;
	assign adv       = !res_v_s1 || out_ready;
	assign take      = cmd_valid && adv && (state_q == S_IDLE);
	assign cmd_pop   = take;
	assign eff_wp    = loading_q ? wp_q : PW'(HDR_BYTES);
	assign eff_sum   = loading_q ? sum_q : 8'd0;
	assign ready     = valid_q && (len_q != '0) && (wp_q == len_q);

	always_comb begin
		state_d   = state_q;
		len_d     = len_q;
		wp_d      = wp_q;
		rp_d      = rp_q;
		valid_d   = valid_q;
		sum_d     = sum_q;
		loading_d = loading_q;
		hdr0_d    = hdr0_q;
		hdr1_d    = hdr1_q;
		idx_d     = idx_q;
		mem_we    = 1'b0;
		mem_wa    = '0;
		mem_wd    = '0;
		mem_re    = 1'b0;
		mem_ra    = '0;
		iss       = 1'b0;
		iss_mem   = 1'b0;
		iss_res   = '0;
		case (state_q)
			S_IDLE: begin
				if (take) begin
					iss = 1'b1;
					case (cmd.kind)
						K_RECV: begin
							if (!valid_q || loading_q) begin
								iss_res.acc = 1'b0;
							end else if (wp_q == '0) begin
								if (cmd.data == start_q) begin
									hdr0_d      = cmd.data;
									wp_d        = PW'(1);
									iss_res.acc = 1'b1;
								end else begin
									valid_d = 1'b0;
								end
							end else if (wp_q == PW'(1)) begin
								if (cmd.data < 8'(MIN_LEN) || cmd.data > 8'(BUF_BYTES)) begin
									valid_d = 1'b0;
								end else begin
									len_d       = cmd.data[PW-1:0];
									hdr1_d      = cmd.data;
									wp_d        = PW'(HDR_BYTES);
									iss_res.acc = 1'b1;
								end
							end else if (wp_q < len_q && wp_q < PW'(BUF_BYTES)) begin
								mem_we      = 1'b1;
								mem_wa      = wp_q[AW-1:0];
								mem_wd      = cmd.data;
								wp_d        = wp_q + 1'b1;
								iss_res.acc = 1'b1;
							end
						end
						K_READ: begin
							if (!ready || len_q < PW'(MIN_LEN)) begin
								iss_res.last = 1'b1;
							end else if (len_q == PW'(MIN_LEN)) begin
								// empty payload: report it and drop the frame
								iss_res.last = 1'b1;
								len_d        = '0;
								wp_d         = '0;
								rp_d         = '0;
								sum_d        = '0;
								loading_d    = 1'b0;
								valid_d      = 1'b1;
							end else begin
								// payload bytes go out from the read state
								iss     = 1'b0;
								idx_d   = AW'(HDR_BYTES);
								state_d = S_READ;
							end
						end
						K_LOAD: begin
							if (loading_q || rp_q == len_q) begin
								if (!loading_q) begin
									hdr0_d    = start_q;
									hdr1_d    = 8'd0;
									rp_d      = '0;
									len_d     = '0;
									loading_d = 1'b1;
								end
								wp_d  = eff_wp;
								sum_d = eff_sum;
								if (eff_wp <= PW'(BUF_BYTES - 2)) begin
									mem_we      = 1'b1;
									mem_wa      = eff_wp[AW-1:0];
									mem_wd      = cmd.data;
									sum_d       = eff_sum + cmd.data;
									wp_d        = eff_wp + 1'b1;
									iss_res.acc = 1'b1;
								end
								if (cmd.last) begin
									state_d = S_SUM;
								end
							end
						end
						K_PULL: begin
							if (loading_q) begin
								iss_res.acc = 1'b0;
							end else if (rp_q == len_q) begin
								valid_d = 1'b0;
							end else if (rp_q < wp_q && rp_q < PW'(BUF_BYTES)) begin
								iss_res.acc = 1'b1;
								rp_d        = rp_q + 1'b1;
								if (rp_q == '0) begin
									iss_res.data = hdr0_q;
								end else if (rp_q == PW'(1)) begin
									iss_res.data = hdr1_q;
								end else begin
									mem_re  = 1'b1;
									mem_ra  = rp_q[AW-1:0];
									iss_mem = 1'b1;
								end
							end
						end
						K_CLEAR: begin
							len_d     = '0;
							wp_d      = '0;
							rp_d      = '0;
							sum_d     = '0;
							loading_d = 1'b0;
							valid_d   = 1'b1;
						end
						default: begin
							iss_res = '0;
						end
					endcase
				end
			end
			S_SUM: begin
				// close the load: append the sum and fix the length byte
				mem_we    = 1'b1;
				mem_wa    = wp_q[AW-1:0];
				mem_wd    = sum_q;
				wp_d      = wp_q + 1'b1;
				len_d     = wp_q + 1'b1;
				hdr1_d    = 8'(wp_q + 1'b1);
				loading_d = 1'b0;
				state_d   = S_IDLE;
			end
			S_READ: begin
				if (adv) begin
					iss          = 1'b1;
					iss_mem      = 1'b1;
					mem_re       = 1'b1;
					mem_ra       = idx_q;
					iss_res.acc  = 1'b1;
					iss_res.plen = PLW'(len_q - PW'(MIN_LEN));
					iss_res.last = (PW'(idx_q) == len_q - PW'(HDR_BYTES));
					if (iss_res.last) begin
						len_d     = '0;
						wp_d      = '0;
						rp_d      = '0;
						sum_d     = '0;
						loading_d = 1'b0;
						valid_d   = 1'b1;
						state_d   = S_IDLE;
					end else begin
						idx_d = idx_q + 1'b1;
					end
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			store_q[mem_wa] <= mem_wd;
		end
		if (mem_re) begin
			rdata_s1 <= store_q[mem_ra];
		end
		if (adv && iss) begin
			res_s1     <= iss_res;
			sel_mem_s1 <= iss_mem;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			start_q   <= START_RESET;
			len_q     <= '0;
			wp_q      <= '0;
			rp_q      <= '0;
			valid_q   <= 1'b1;
			sum_q     <= '0;
			loading_q <= 1'b0;
			hdr0_q    <= '0;
			hdr1_q    <= '0;
			idx_q     <= '0;
			res_v_s1  <= 1'b0;
		end else begin
			if (cfg_we) begin
				start_q <= cfg_data;
			end
			state_q   <= state_d;
			len_q     <= len_d;
			wp_q      <= wp_d;
			rp_q      <= rp_d;
			valid_q   <= valid_d;
			sum_q     <= sum_d;
			loading_q <= loading_d;
			hdr0_q    <= hdr0_d;
			hdr1_q    <= hdr1_d;
			idx_q     <= idx_d;
			if (adv) begin
				res_v_s1 <= iss;
			end
		end
	end

	always_comb begin
		res      = res_s1;
		res.data = sel_mem_s1 ? rdata_s1 : res_s1.data;
	end
	assign res_push = res_v_s1 && out_ready;

	`BPFD_ASSERT(a_wp_bound, wp_q <= PW'(BUF_BYTES))
	`BPFD_ASSERT(a_rp_le_wp, rp_q <= wp_q)
	`BPFD_ASSERT(a_sum_in_load, (state_q != S_SUM) || loading_q)
	`BPFD_ASSERT_NEXT(a_res_hold, res_v_s1 && !out_ready, res_v_s1)

endmodule

// ===== src/byte_packet_framer_deframer.sv =====
// A result goes through the input queue, the core result stage and the output queue.
// Throughput: one operation per cycle while the core is idle and the output queue has room;
// a read first enters the read state, then gives one payload byte per cycle from the frame
// store while the output queue has room; after a closing load byte a sum state writes the sum.
// Reset (arst_n low, asynchronous): queues empty, buffer cleared and valid, start byte 0x55;
// frame store contents are not cleared.
module byte_packet_framer_deframer
	import bpfd_pkg::*;
(
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cfg_we,
	input  logic [7:0]     cfg_data,
	input  logic           push,
	output logic           full,
	input  logic [2:0]     operation,
	input  logic [7:0]     data_in,
	input  logic           load_last,
	output logic           empty,
	input  logic           pop,
	output logic [7:0]     data_out,
	output logic           accepted,
	output logic           last,
	output logic [PLW-1:0] payload_length
);

	// front: take and classify operations into a short command queue
	cmd_t cmd;
	logic cmd_valid;
	logic cmd_pop;

	// back: result transfers toward the output queue
	res_t res;
	res_t res_out;
	logic res_push;
	logic res_full;

	bpfd_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.operation (operation),
		.data_in   (data_in),
		.load_last (load_last),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_pop   (cmd_pop)
	);

	// core: frame buffer state, frame store, and the read/sum sequencer
	bpfd_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_data  (cfg_data),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_pop   (cmd_pop),
		.out_full  (res_full),
		.res_push  (res_push),
		.res       (res)
	);

	// hold finished results until the consumer pops them
	bpfd_outq u_outq (
		.clk      (clk),
		.arst_n   (arst_n),
		.res_push (res_push),
		.res_in   (res),
		.res_full (res_full),
		.empty    (empty),
		.pop      (pop),
		.res_out  (res_out)
	);

	assign data_out       = res_out.data;
	assign accepted       = res_out.acc;
	assign last           = res_out.last;
	assign payload_length = res_out.plen;

endmodule

// ===== test/bpfd_checker.sv =====
`timescale 1ns / 1ps

module bpfd_checker
	import bpfd_pkg::*;
(
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cfg_we,
	input  logic [7:0]     cfg_data,
	input  logic           push,
	input  logic           full,
	input  logic [2:0]     operation,
	input  logic [7:0]     data_in,
	input  logic           load_last,
	input  logic           empty,
	input  logic           pop,
	input  logic [7:0]     data_out,
	input  logic           accepted,
	input  logic           last,
	input  logic [PLW-1:0] payload_length,
	output int             fail_count,
	output int             pending
);

	logic [7:0] frame_mem [BUF_BYTES];
	logic [6:0] flen;
	logic [6:0] wpos;
	logic [6:0] rpos;
	logic       fvalid;
	logic       loading_q;
	logic [7:0] rsum;
	logic [7:0] start_q;
	res_t       owed_res [$];
	res_t       want;

	task automatic owe(input logic [7:0] d, input logic a, input logic l,
			input logic [PLW-1:0] p);
		owed_res.push_back(res_t'{data: d, acc: a, last: l, plen: p});
	endtask

	task automatic drop_frame();
		flen      = '0;
		wpos      = '0;
		rpos      = '0;
		rsum      = '0;
		loading_q = 1'b0;
		fvalid    = 1'b1;
	endtask

	// Work out the transfers one operation owes and update the buffer state.
	task automatic run_frame_op(input logic [2:0] op, input logic [7:0] b, input logic ll);
		logic       acc;
		logic       go;
		logic [7:0] dout;
		int         i;
		acc  = 1'b0;
		dout = '0;
		case (op)
			OPC_RECV: begin
				if (!fvalid || loading_q) begin
					acc = 1'b0;
				end else if (wpos == 0) begin
					if (b == start_q) begin
						frame_mem[0] = b;
						wpos = 7'd1;
						acc  = 1'b1;
					end else begin
						fvalid = 1'b0;
					end
				end else if (wpos == 1) begin
					if (b < MIN_LEN || b > BUF_BYTES) begin
						fvalid = 1'b0;
					end else begin
						flen = b[6:0];
						frame_mem[1] = b;
						wpos = 7'd2;
						acc  = 1'b1;
					end
				end else if (wpos < flen && wpos < BUF_BYTES) begin
					frame_mem[wpos] = b;
					wpos = wpos + 7'd1;
					acc  = 1'b1;
				end
			end
			OPC_READ: begin
				if (fvalid && flen >= MIN_LEN && wpos == flen) begin
					if (flen == MIN_LEN) begin
						owe('0, 1'b0, 1'b1, '0);
					end else begin
						for (i = 0; i < flen - MIN_LEN; i++)
							owe(frame_mem[HDR_BYTES + i], 1'b1, i == flen - MIN_LEN - 1,
								PLW'(flen - MIN_LEN));
					end
					drop_frame();
				end else begin
					owe('0, 1'b0, 1'b1, '0);
				end
			end
			OPC_LOAD: begin
				go = 1'b1;
				if (!loading_q) begin
					if (rpos != flen) begin
						go = 1'b0;
					end else begin
						frame_mem[0] = start_q;
						frame_mem[1] = '0;
						wpos      = 7'd2;
						rpos      = '0;
						flen      = '0;
						rsum      = '0;
						loading_q = 1'b1;
					end
				end
				if (go) begin
					if (wpos <= BUF_BYTES - 2) begin
						frame_mem[wpos] = b;
						rsum = rsum + b;
						wpos = wpos + 7'd1;
						acc  = 1'b1;
					end
					if (ll) begin
						frame_mem[wpos] = rsum;
						wpos = wpos + 7'd1;
						flen = wpos;
						frame_mem[1] = {1'b0, flen};
						loading_q = 1'b0;
					end
				end
			end
			OPC_PULL: begin
				if (loading_q) begin
					acc = 1'b0;
				end else if (rpos == flen) begin
					fvalid = 1'b0;
				end else if (rpos < wpos && rpos < BUF_BYTES) begin
					dout = frame_mem[rpos];
					rpos = rpos + 7'd1;
					acc  = 1'b1;
				end
			end
			OPC_CLEAR: begin
				drop_frame();
			end
			default: begin
			end
		endcase
		if (op != OPC_READ)
			owe(dout, acc, 1'b0, '0);
	endtask

	task automatic check_field(input string what, input logic [7:0] exp_v,
			input logic [7:0] got_v);
		if (got_v !== exp_v) begin
			fail_count++;
			$display("%0t: %s expected %0d, got %0d", $time, what, exp_v, got_v);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			foreach (frame_mem[k])
				frame_mem[k] = '0;
			drop_frame();
			start_q    = START_RESET;
			fail_count = 0;
			owed_res.delete();
		end else begin
			if (pop && !empty) begin
				if (owed_res.size() == 0) begin
					fail_count++;
					$display("%0t: unexpected result data %0d accepted %0b last %0b length %0d",
						$time, data_out, accepted, last, payload_length);
				end else begin
					want = owed_res.pop_front();
					check_field("data_out", want.data, data_out);
					check_field("accepted", want.acc, accepted);
					check_field("last", want.last, last);
					check_field("payload_length", want.plen, payload_length);
				end
			end
			if (cfg_we)
				start_q = cfg_data;
			if (push && !full)
				run_frame_op(operation, data_in, load_last);
		end
		pending = owed_res.size();
	end

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 1ps

module tb
	import bpfd_pkg::*;
();

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int HOLD_CYCLES    = 150;
	localparam int PHASE_ITEMS    = 2;

	// flaws injected into a received frame
	localparam int RX_BAD_START = 0;
	localparam int RX_BAD_LEN   = 1;
	localparam int RX_NO_SUM    = 2;
	localparam int RX_BAD_SUM   = 3;
	localparam int RX_PULL      = 4;
	localparam int RX_TRAILER   = 5;
	// flaws injected into a transmitted frame
	localparam int TX_READ      = 0;
	localparam int TX_REFUSED   = 1;
	localparam int TX_INTERRUPT = 2;
	// highest flaw draw; anything not listed above is a clean frame
	localparam int CLEAN        = 12;

	logic           clk;
	logic           arst_n;
	logic           cfg_we;
	logic [7:0]     cfg_data;
	logic           push;
	logic           full;
	logic [2:0]     operation;
	logic [7:0]     data_in;
	logic           load_last;
	logic           empty;
	logic           pop;
	logic [7:0]     data_out;
	logic           accepted;
	logic           last;
	logic [PLW-1:0] payload_length;

	int         fail_count;
	int         pending;
	int         sent;
	int         idle_cycles = 0;
	logic [7:0] cur_start;
	// hold_req asks the result side for one long hold-off; burst drops all idling
	bit         hold_req;
	bit         burst;

	byte_packet_framer_deframer u_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_data       (cfg_data),
		.push           (push),
		.full           (full),
		.operation      (operation),
		.data_in        (data_in),
		.load_last      (load_last),
		.empty          (empty),
		.pop            (pop),
		.data_out       (data_out),
		.accepted       (accepted),
		.last           (last),
		.payload_length (payload_length)
	);

	bpfd_checker u_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_data       (cfg_data),
		.push           (push),
		.full           (full),
		.operation      (operation),
		.data_in        (data_in),
		.load_last      (load_last),
		.empty          (empty),
		.pop            (pop),
		.data_out       (data_out),
		.accepted       (accepted),
		.last           (last),
		.payload_length (payload_length),
		.fail_count     (fail_count),
		.pending        (pending)
	);

	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	// Watchdog: end the run when no transfer of any kind happens for too long.
	always @(posedge clk) begin
		if (!arst_n || (push && !full) || (pop && !empty) || cfg_we) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
			$display("Some tests failed");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	function automatic logic [7:0] any_byte();
		return 8'($urandom_range(0, 255));
	endfunction

	function automatic logic any_bit();
		return 1'($urandom_range(0, 1));
	endfunction

	// Mostly short payloads, now and then anything up to the given count.
	function automatic int pick_count(input int most);
		return ($urandom_range(0, 11) == 0) ? $urandom_range(0, most) : $urandom_range(0, 8);
	endfunction

	// Offer one operation after a random gap and hold it until the transfer.
	// Return at the next falling edge with push still high, so a following
	// operation with no gap goes out back to back.
	task automatic send_op(input logic [2:0] op, input logic [7:0] b, input logic ll);
		int gap;
		gap = burst ? 0 : $urandom_range(0, 19);
		if (gap > 0) begin
			push <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		push      <= 1'b1;
		operation <= op;
		data_in   <= b;
		load_last <= ll;
		do @(posedge clk); while (full);
		@(negedge clk);
		sent++;
	endtask

	// Write the start byte only once every owed result has come out.
	task automatic set_start(input logic [7:0] v);
		push <= 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (8) @(negedge clk);
		cfg_we   <= 1'b1;
		cfg_data <= v;
		@(negedge clk);
		cfg_we    <= 1'b0;
		cur_start = v;
	endtask

	// Feed one line frame of n payload bytes, optionally damaged, then read it.
	task automatic rx_frame(input int n, input int flaw);
		int         i;
		logic [7:0] b;
		logic [7:0] sum;
		sum = '0;
		if ($urandom_range(0, 4) != 0)
			send_op(OPC_CLEAR, any_byte(), any_bit());
		b = cur_start;
		if (flaw == RX_BAD_START)
			b = cur_start ^ 8'($urandom_range(1, 255));
		send_op(OPC_RECV, b, any_bit());
		if (flaw == RX_BAD_LEN)
			b = $urandom_range(0, 1) ? 8'($urandom_range(0, MIN_LEN - 1))
				: 8'($urandom_range(BUF_BYTES + 1, 255));
		else
			b = 8'(n + MIN_LEN);
		send_op(OPC_RECV, b, any_bit());
		for (i = 0; i < n; i++) begin
			b = any_byte();
			sum = sum + b;
			send_op(OPC_RECV, b, any_bit());
		end
		if (flaw != RX_NO_SUM)
			send_op(OPC_RECV, (flaw == RX_BAD_SUM) ? any_byte() : sum, any_bit());
		if (flaw == RX_TRAILER)
			send_op(OPC_RECV, any_byte(), any_bit());
		if (flaw == RX_PULL)
			repeat ($urandom_range(1, 4)) send_op(OPC_PULL, any_byte(), any_bit());
		send_op(OPC_READ, any_byte(), any_bit());
	endtask

	// Load n payload bytes (n >= 1), then pull the frame out or disturb it.
	task automatic tx_frame(input int n, input int flaw);
		int i;
		int total;
		if ($urandom_range(0, 4) != 0)
			send_op(OPC_CLEAR, any_byte(), any_bit());
		for (i = 0; i < n; i++) begin
			send_op(OPC_LOAD, any_byte(), i == n - 1);
			// with more than one byte, pull, receive and read must all bounce off the running load
			if (flaw == TX_INTERRUPT && i == 0) begin
				send_op(OPC_PULL, any_byte(), any_bit());
				send_op(OPC_RECV, cur_start, any_bit());
				send_op(OPC_READ, any_byte(), any_bit());
			end
		end
		total = ((n > BUF_BYTES - MIN_LEN) ? BUF_BYTES - MIN_LEN : n) + MIN_LEN;
		case (flaw)
			TX_READ: begin
				send_op(OPC_READ, any_byte(), any_bit());
			end
			TX_REFUSED: begin
				repeat ($urandom_range(1, total - 1)) send_op(OPC_PULL, any_byte(), any_bit());
				send_op(OPC_LOAD, any_byte(), any_bit());
				send_op(OPC_CLEAR, any_byte(), any_bit());
			end
			default: begin
				// one pull past the end drops the valid mark
				repeat (total + 1) send_op(OPC_PULL, any_byte(), any_bit());
			end
		endcase
	endtask

	// any operation code, the unused ones too
	task automatic line_noise();
		repeat ($urandom_range(1, 4))
			send_op(3'($urandom_range(0, 7)), any_byte(), any_bit());
	endtask

	task automatic random_phase(input int count);
		int stop;
		stop = sent + count;
		while (sent < stop) begin
			burst = ($urandom_range(0, 3) == 0);
			case ($urandom_range(0, 9))
				0, 1, 2, 3: begin
					rx_frame(pick_count(BUF_BYTES - MIN_LEN), $urandom_range(0, CLEAN));
				end
				4, 5, 6, 7: begin
					tx_frame(1 + pick_count(BUF_BYTES - 1), $urandom_range(0, CLEAN));
				end
				default: begin
					line_noise();
				end
			endcase
		end
		burst = 1'b0;
	endtask

	// Result side: pop after a random hold-off, or the long one when asked.
	initial begin
		int wait_n;
		pop = 1'b0;
		@(posedge arst_n);
		forever begin
			if (hold_req) begin
				hold_req = 1'b0;
				pop <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
			end else begin
				wait_n = burst ? 0 : $urandom_range(0, 19);
				if (wait_n > 0) begin
					pop <= 1'b0;
					repeat (wait_n) @(negedge clk);
				end
			end
			pop <= 1'b1;
			do @(posedge clk); while (empty);
			@(negedge clk);
		end
	end

	initial begin
		arst_n    = 1'b0;
		cfg_we    = 1'b0;
		cfg_data  = '0;
		push      = 1'b0;
		operation = OPC_RECV;
		data_in   = '0;
		load_last = 1'b0;
		hold_req  = 1'b0;
		burst     = 1'b0;
		sent      = 0;
		cur_start = START_RESET;
		repeat (8) @(negedge clk);
		arst_n = 1'b1;

		// Read with nothing ready, then pull with nothing left: the valid mark
		// drops and receive bytes are ignored until a clear.
		send_op(OPC_READ, any_byte(), any_bit());
		send_op(OPC_PULL, any_byte(), any_bit());
		send_op(OPC_RECV, START_RESET, 1'b0);
		send_op(OPC_CLEAR, any_byte(), any_bit());

		// Well-formed frame with extreme payload bytes, one byte past its end,
		// then read it out.
		send_op(OPC_RECV, START_RESET, 1'b0);
		send_op(OPC_RECV, 8'd5, 1'b1);
		send_op(OPC_RECV, 8'hFF, 1'b0);
		send_op(OPC_RECV, 8'h00, 1'b1);
		send_op(OPC_RECV, 8'hFF, 1'b0);
		send_op(OPC_RECV, 8'hA5, 1'b1);
		send_op(OPC_READ, any_byte(), any_bit());

		// Wrong start byte, length below the minimum, length above the buffer.
		send_op(OPC_RECV, 8'hAA, 1'b0);
		send_op(OPC_CLEAR, any_byte(), any_bit());
		send_op(OPC_RECV, START_RESET, 1'b0);
		send_op(OPC_RECV, 8'd2, 1'b0);
		send_op(OPC_CLEAR, any_byte(), any_bit());
		send_op(OPC_RECV, START_RESET, 1'b0);
		send_op(OPC_RECV, 8'(BUF_BYTES + 1), 1'b0);
		send_op(OPC_CLEAR, any_byte(), any_bit());

		// Length equal to the buffer size is taken.
		send_op(OPC_RECV, START_RESET, 1'b0);
		send_op(OPC_RECV, 8'(BUF_BYTES), 1'b0);
		send_op(OPC_CLEAR, any_byte(), any_bit());

		// Frame with no payload: the read reports zero length and clears.
		send_op(OPC_RECV, START_RESET, 1'b0);
		send_op(OPC_RECV, 8'(MIN_LEN), 1'b0);
		send_op(OPC_RECV, 8'h00, 1'b0);
		send_op(OPC_READ, any_byte(), any_bit());

		// Load a one-byte frame, pull part of it; a new load is refused.
		send_op(OPC_LOAD, 8'hFF, 1'b1);
		send_op(OPC_PULL, any_byte(), any_bit());
		send_op(OPC_PULL, any_byte(), any_bit());
		send_op(OPC_LOAD, 8'h00, 1'b0);
		send_op(OPC_CLEAR, any_byte(), any_bit());

		// Lowest start byte; largest transmit frame, the load overflowing.
		set_start(8'h00);
		tx_frame(BUF_BYTES - 1, TX_READ);
		random_phase(PHASE_ITEMS);

		// Highest start byte; stall the result side while loads keep coming
		// so both queues fill and push backs up.
		set_start(8'hFF);
		burst    = 1'b1;
		hold_req = 1'b1;
		tx_frame(6, CLEAN);
		burst = 1'b0;
		random_phase(PHASE_ITEMS);

		set_start(8'($urandom_range(1, 254)));
		random_phase(PHASE_ITEMS);

		set_start(START_RESET);
		random_phase(PHASE_ITEMS);

		// Drain, then give stray results time to show up.
		push <= 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (20) @(negedge clk);
		if (fail_count == 0 && pending == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

// ===== sim.f =====
+incdir+src
src/bpfd_pkg.sv
src/bpfd_front.sv
src/bpfd_outq.sv
src/bpfd_core.sv
src/byte_packet_framer_deframer.sv
test/bpfd_checker.sv
test/tb.sv
